// ===== rtl/c3br_pkg.sv =====
// c3br_pkg: shared constants, config register codes and the result tag struct
// for the 3x3 convolution stream block; no dependencies
package c3br_pkg;

	localparam int MAX_SIZE_DEF   = 256;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int COEF_BITS      = 16;
	localparam int SUM_BITS       = 32;
	localparam int COORD_BITS     = 8;
	localparam int FS_BITS        = 9;
	localparam int CFG_DATA_BITS  = 48;
	localparam int CFG_INDEX_BITS = 3;
	localparam int ROUND_SHIFT    = 6;
	localparam int TAPS           = 9;

	localparam logic [FS_BITS-1:0] FS_RESET = 9'd224;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_KERNEL_TOP = 3'd0,
		CFG_KERNEL_MID = 3'd1,
		CFG_KERNEL_BOT = 3'd2,
		CFG_BIAS       = 3'd3,
		CFG_FRAME_SIZE = 3'd4
	} cfg_index_t;

	typedef logic signed [COEF_BITS-1:0] coef_t;

	// everything that travels with a window besides its pixels
	typedef struct packed {
		logic signed [SUM_BITS-1:0] partial_sum;
		logic                       final_channel;
		logic [COORD_BITS-1:0]      row;
		logic [COORD_BITS-1:0]      col;
		logic                       frame_end;
	} tag_t;

endpackage

// ===== rtl/c3br_stream_ifs.sv =====
// c3br_stream_ifs: valid/ready stream interfaces for samples and results
// depends on c3br_pkg
interface c3br_in_if #(
	parameter int PIXEL_BITS = c3br_pkg::PIXEL_BITS_DEF
) ();
	logic                                     valid;
	logic                                     ready;
	logic signed [PIXEL_BITS-1:0]             pixel;
	logic signed [c3br_pkg::SUM_BITS-1:0]     partial_sum;
	logic                                     final_channel;

	modport source (output valid, pixel, partial_sum, final_channel, input ready);
	modport sink   (input valid, pixel, partial_sum, final_channel, output ready);
endinterface

interface c3br_out_if ();
	logic                                     valid;
	logic                                     ready;
	logic signed [c3br_pkg::SUM_BITS-1:0]     result;
	logic [c3br_pkg::COORD_BITS-1:0]          out_row;
	logic [c3br_pkg::COORD_BITS-1:0]          out_col;
	logic                                     frame_end;

	modport source (output valid, result, out_row, out_col, frame_end, input ready);
	modport sink   (input valid, result, out_row, out_col, frame_end, output ready);
endinterface

// ===== rtl/c3br_window.sv =====
// c3br_window: line stores, 3x3 window, padded-plane position and input stage
// depends on c3br_pkg and c3br_in_if
module c3br_window #(
	parameter int MAX_SIZE   = c3br_pkg::MAX_SIZE_DEF,
	parameter int PIXEL_BITS = c3br_pkg::PIXEL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	c3br_in_if.sink                           samples,
	input  logic [c3br_pkg::FS_BITS-1:0]      frame_size,
	output logic signed [PIXEL_BITS-1:0]      win_s1 [c3br_pkg::TAPS],
	output c3br_pkg::tag_t                    tag_s1,
	output logic                              valid_s1,
	input  logic                              ready_s1
);
	localparam int LINE_DEPTH = MAX_SIZE + 2;
	localparam int POS_W      = $clog2(LINE_DEPTH);
	localparam int CW         = (POS_W > c3br_pkg::FS_BITS ? POS_W : c3br_pkg::FS_BITS) + 2;

	logic [PIXEL_BITS-1:0] upper_mem [LINE_DEPTH];
	logic [PIXEL_BITS-1:0] lower_mem [LINE_DEPTH];
	logic [PIXEL_BITS-1:0] rd_upper_q, rd_lower_q;

	logic signed [PIXEL_BITS-1:0] win_q   [c3br_pkg::TAPS];
	logic signed [PIXEL_BITS-1:0] win_nxt [c3br_pkg::TAPS];

	logic [POS_W-1:0] row_q, col_q, row_nxt, col_nxt, rd_addr;
	logic [CW-1:0]    fs_ext, n_eff, w_eff, r_ext, c_ext, orow, ocol;
	logic             produced, col_wrap, accept, adv_s1;
	c3br_pkg::tag_t   tag_nxt;

	assign adv_s1        = !valid_s1 || ready_s1;
	assign samples.ready = adv_s1;
	assign accept        = samples.valid && adv_s1;

	always_comb begin
		fs_ext = CW'(frame_size);
		if (fs_ext == '0) begin
			n_eff = CW'(1);
		end else if (fs_ext > CW'(MAX_SIZE)) begin
			n_eff = CW'(MAX_SIZE);
		end else begin
			n_eff = fs_ext;
		end
		w_eff = n_eff + CW'(2);
		r_ext = CW'(row_q);
		c_ext = CW'(col_q);
		orow  = r_ext - CW'(2);
		ocol  = c_ext - CW'(2);
		produced = (r_ext >= CW'(2)) && (c_ext >= CW'(2)) && (r_ext < w_eff) && (c_ext < w_eff);

		col_wrap = (c_ext + CW'(1)) >= w_eff;
		if (col_wrap) begin
			col_nxt = '0;
			row_nxt = ((r_ext + CW'(1)) >= w_eff) ? '0 : POS_W'(r_ext + CW'(1));
		end else begin
			col_nxt = POS_W'(c_ext + CW'(1));
			row_nxt = row_q;
		end
		// prefetch the column the next sample will need
		rd_addr = accept ? col_nxt : col_q;

		for (int k = 0; k < 3; k++) begin
			win_nxt[k*3]   = win_q[k*3+1];
			win_nxt[k*3+1] = win_q[k*3+2];
		end
		win_nxt[2] = $signed(rd_upper_q);
		win_nxt[5] = $signed(rd_lower_q);
		win_nxt[8] = samples.pixel;

		tag_nxt.partial_sum   = samples.partial_sum;
		tag_nxt.final_channel = samples.final_channel;
		tag_nxt.row           = orow[c3br_pkg::COORD_BITS-1:0];
		tag_nxt.col           = ocol[c3br_pkg::COORD_BITS-1:0];
		tag_nxt.frame_end     = (orow == n_eff - CW'(1)) && (ocol == n_eff - CW'(1));
	end

	// line stores: one registered read each per cycle, and one write each per accepted sample
	always_ff @(posedge clk) begin
		rd_upper_q <= upper_mem[rd_addr];
		rd_lower_q <= lower_mem[rd_addr];
		if (accept) begin
			upper_mem[col_q] <= rd_lower_q;
			lower_mem[col_q] <= samples.pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
			for (int i = 0; i < c3br_pkg::TAPS; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (adv_s1) begin
				valid_s1 <= accept && produced;
			end
			if (accept) begin
				row_q <= row_nxt;
				col_q <= col_nxt;
				win_q <= win_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_s1 <= win_nxt;
			tag_s1 <= tag_nxt;
		end
	end

	a_col_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(col_q) < CW'(LINE_DEPTH))
		else $error("column position beyond line store");

	a_window_issued: assert property (@(posedge clk) disable iff (!arst_n)
		accept && produced |=> valid_s1)
		else $error("completed window not issued");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s1 |=> valid_s1 && $stable(tag_s1))
		else $error("stalled window lost or changed");

endmodule

// ===== rtl/c3br_mac.sv =====
// c3br_mac: nine-tap multiply, summation, rounding, bias, saturation and relu
// pipeline with output register; depends on c3br_pkg and c3br_out_if
module c3br_mac #(
	parameter int PIXEL_BITS = c3br_pkg::PIXEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [PIXEL_BITS-1:0]        win_s1 [c3br_pkg::TAPS],
	input  c3br_pkg::tag_t                      tag_s1,
	input  logic                                valid_s1,
	output logic                                ready_s1,
	input  c3br_pkg::coef_t                     coefs [c3br_pkg::TAPS],
	input  logic signed [c3br_pkg::SUM_BITS-1:0] bias,
	c3br_out_if.source                          results
);
	localparam int SB  = c3br_pkg::SUM_BITS;
	localparam int PW  = PIXEL_BITS + c3br_pkg::COEF_BITS;
	localparam int RW  = PW + 2;
	localparam int AW  = PW + 4;
	localparam int CVW = AW - c3br_pkg::ROUND_SHIFT;
	localparam int TW  = (CVW > SB ? CVW : SB) + 2;

	localparam logic signed [TW-1:0] SAT_MAX = $signed({{(TW-SB){1'b0}}, 1'b0, {(SB-1){1'b1}}});
	localparam logic signed [TW-1:0] SAT_MIN = $signed({{(TW-SB){1'b1}}, 1'b1, {(SB-1){1'b0}}});
	localparam logic signed [AW-1:0] RND     = AW'(1 << (c3br_pkg::ROUND_SHIFT - 1));

	logic signed [PW-1:0]  prod_s2 [c3br_pkg::TAPS];
	logic signed [RW-1:0]  rsum_s3 [3];
	logic signed [CVW-1:0] conv_s4;
	c3br_pkg::tag_t        tag_s2, tag_s3, tag_s4;
	logic                  v2, v3, v4, v5, final_s5;
	logic                  adv2, adv3, adv4, adv5;

	logic signed [AW-1:0]  acc;
	logic signed [TW-1:0]  total;
	logic signed [SB-1:0]  res_nxt;

	assign adv5     = !v5 || results.ready;
	assign adv4     = !v4 || adv5;
	assign adv3     = !v3 || adv4;
	assign adv2     = !v2 || adv3;
	assign ready_s1 = adv2;

	always_comb begin
		acc = AW'(rsum_s3[0]) + AW'(rsum_s3[1]) + AW'(rsum_s3[2]) + RND;
		total = TW'(conv_s4) + TW'(tag_s4.partial_sum)
			+ (tag_s4.final_channel ? TW'(bias) : TW'(0));
		if (total > SAT_MAX) begin
			res_nxt = SB'(SAT_MAX);
		end else if (total < SAT_MIN) begin
			res_nxt = SB'(SAT_MIN);
		end else begin
			res_nxt = SB'(total);
		end
		if (tag_s4.final_channel && res_nxt[SB-1]) begin
			res_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
		end else begin
			if (adv2) v2 <= valid_s1;
			if (adv3) v3 <= v2;
			if (adv4) v4 <= v3;
			if (adv5) v5 <= v4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int i = 0; i < c3br_pkg::TAPS; i++) begin
				prod_s2[i] <= PW'(win_s1[i]) * PW'(coefs[i]);
			end
			tag_s2 <= tag_s1;
		end
		if (adv3) begin
			for (int k = 0; k < 3; k++) begin
				rsum_s3[k] <= RW'(prod_s2[k*3]) + RW'(prod_s2[k*3+1]) + RW'(prod_s2[k*3+2]);
			end
			tag_s3 <= tag_s2;
		end
		if (adv4) begin
			// floor of (sum + half lsb) / 64: Q10.22 down to Q16.16
			conv_s4 <= CVW'(acc >>> c3br_pkg::ROUND_SHIFT);
			tag_s4  <= tag_s3;
		end
		if (adv5) begin
			results.result    <= res_nxt;
			results.out_row   <= tag_s4.row;
			results.out_col   <= tag_s4.col;
			results.frame_end <= tag_s4.frame_end;
			final_s5          <= tag_s4.final_channel;
		end
	end

	assign results.valid = v5;

	a_relu_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		v5 && final_s5 |-> !results.result[SB-1])
		else $error("negative result on final channel");

	a_end_diag: assert property (@(posedge clk) disable iff (!arst_n)
		v5 && results.frame_end |-> results.out_row == results.out_col)
		else $error("frame end off the diagonal");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v4 && v5 && !results.ready |=> v4 && $stable(tag_s4))
		else $error("stage four lost under stall");

endmodule

// ===== rtl/conv3x3_bias_relu_stream.sv =====
// conv3x3_bias_relu_stream: top level, configuration registers and the two
// pipeline parts; depends on c3br_pkg, c3br_stream_ifs, c3br_window, c3br_mac
//
//  channel   | dir | transfer moves
//  ----------+-----+-----------------------------------------------------
//  samples   | in  | pixel (Q8.8), partial_sum (Q16.16), final_channel
//  results   | out | result (Q16.16), out_row, out_col, frame_end
//  wr_*      | in  | write enable, register index, data (no handshake)
//
// one sample transfer per cycle sustained while results are taken; a result
// leaves five register stages after its sample: window/input stage, products,
// row sums, rounded sum, saturated output register
// reset clears positions, window, stage valids and config (frame_size 224);
// line stores are not cleared and need no clearing pass
// a stalled results channel holds the output register; bubbles in the
// pipeline still absorb samples until the stall reaches the input stage
module conv3x3_bias_relu_stream #(
	parameter int MAX_SIZE   = c3br_pkg::MAX_SIZE_DEF,
	parameter int PIXEL_BITS = c3br_pkg::PIXEL_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	c3br_in_if.sink                                samples,
	c3br_out_if.source                             results,
	input  logic                                   wr_en,
	input  logic [c3br_pkg::CFG_INDEX_BITS-1:0]    wr_index,
	input  logic [c3br_pkg::CFG_DATA_BITS-1:0]     wr_data
);
	localparam int CB = c3br_pkg::COEF_BITS;

	// kernel rows, column 0 in the low bits
	logic [c3br_pkg::CFG_DATA_BITS-1:0]  kernel_q [3];
	logic signed [c3br_pkg::SUM_BITS-1:0] bias_q;
	logic [c3br_pkg::FS_BITS-1:0]        frame_size_q;

	c3br_pkg::coef_t              coefs [c3br_pkg::TAPS];
	logic signed [PIXEL_BITS-1:0] win_s1 [c3br_pkg::TAPS];
	c3br_pkg::tag_t               tag_s1;
	logic                         valid_s1, ready_s1;

	// config writes; indices past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q[0]  <= '0;
			kernel_q[1]  <= '0;
			kernel_q[2]  <= '0;
			bias_q       <= '0;
			frame_size_q <= c3br_pkg::FS_RESET;
		end else if (wr_en) begin
			case (c3br_pkg::cfg_index_t'(wr_index))
				c3br_pkg::CFG_KERNEL_TOP: kernel_q[0]  <= wr_data;
				c3br_pkg::CFG_KERNEL_MID: kernel_q[1]  <= wr_data;
				c3br_pkg::CFG_KERNEL_BOT: kernel_q[2]  <= wr_data;
				c3br_pkg::CFG_BIAS:       bias_q       <= $signed(wr_data[c3br_pkg::SUM_BITS-1:0]);
				c3br_pkg::CFG_FRAME_SIZE: frame_size_q <= wr_data[c3br_pkg::FS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// unpack coefficients, tap index is row * 3 + column
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int l = 0; l < 3; l++) begin
				coefs[k*3+l] = $signed(kernel_q[k][CB*l +: CB]);
			end
		end
	end

	c3br_window #(
		.MAX_SIZE   (MAX_SIZE),
		.PIXEL_BITS (PIXEL_BITS)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.frame_size (frame_size_q),
		.win_s1     (win_s1),
		.tag_s1     (tag_s1),
		.valid_s1   (valid_s1),
		.ready_s1   (ready_s1)
	);

	c3br_mac #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.win_s1   (win_s1),
		.tag_s1   (tag_s1),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1),
		.coefs    (coefs),
		.bias     (bias_q),
		.results  (results)
	);

endmodule

// ===== tb/sv/c3br_result_checker.sv =====
`timescale 1ns / 100ps
// c3br_result_checker: shadow model of the 3x3 convolution stream that predicts and
// checks every result transfer; depends on c3br_pkg and c3br_stream_ifs
module c3br_result_checker
	import c3br_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	c3br_in_if                        samples,
	c3br_out_if                       results,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [CFG_DATA_BITS-1:0]  wr_data,
	output int                        error_count,
	output int                        pending,
	output int                        results_checked
);

	localparam int     LINE_DEPTH = MAX_SIZE_DEF + 2;
	localparam longint SUM_MAX    = 64'sd2147483647;
	localparam longint SUM_MIN    = -64'sd2147483648;
	localparam int     SHOW_MAX   = 40;

	typedef struct packed {
		logic signed [SUM_BITS-1:0] value;
		logic [COORD_BITS-1:0]      row;
		logic [COORD_BITS-1:0]      col;
		logic                       last;
	} conv_out_t;

	// shadow registers
	logic [CFG_DATA_BITS-1:0]         kernel_rows [3];
	logic signed [SUM_BITS-1:0]       bias_reg;
	logic [FS_BITS-1:0]               size_reg;

	// shadow line buffers, window and scan position in the padded plane
	logic signed [PIXEL_BITS_DEF-1:0] upper_row_buf [LINE_DEPTH];
	logic signed [PIXEL_BITS_DEF-1:0] lower_row_buf [LINE_DEPTH];
	logic signed [PIXEL_BITS_DEF-1:0] taps [TAPS];
	int unsigned                      scan_row;
	int unsigned                      scan_col;

	conv_out_t                        due_results [$];
	conv_out_t                        want;

	initial begin
		error_count = 0;
		pending = 0;
		results_checked = 0;
		for (int i = 0; i < 3; i++)
			kernel_rows[i] = '0;
		bias_reg = '0;
		size_reg = FS_RESET;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			upper_row_buf[i] = '0;
			lower_row_buf[i] = '0;
		end
		for (int i = 0; i < TAPS; i++)
			taps[i] = '0;
		scan_row = 0;
		scan_col = 0;
	end

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= SHOW_MAX)
			$display("%0t checker: %s", $time, msg);
	endtask

	// slide the window by one sample and queue the convolution it completes, if any
	task automatic convolve_sample(input logic signed [PIXEL_BITS_DEF-1:0] px,
			input logic signed [SUM_BITS-1:0] psum, input logic last_chan);
		int unsigned n, w, r, c;
		int          k, l;
		longint      acc, total;
		conv_out_t   res;
		n = size_reg;
		if (n < 1)
			n = 1;
		if (n > MAX_SIZE_DEF)
			n = MAX_SIZE_DEF;
		w = n + 2;
		r = scan_row;
		c = scan_col;
		for (k = 0; k < 3; k++) begin
			taps[k*3]   = taps[k*3+1];
			taps[k*3+1] = taps[k*3+2];
		end
		if (c < LINE_DEPTH) begin
			taps[2] = upper_row_buf[c];
			taps[5] = lower_row_buf[c];
			upper_row_buf[c] = lower_row_buf[c];
			lower_row_buf[c] = px;
		end else begin
			taps[2] = '0;
			taps[5] = '0;
		end
		taps[8] = px;
		if (r >= 2 && c >= 2 && r < w && c < w) begin
			acc = 0;
			for (k = 0; k < 3; k++)
				for (l = 0; l < 3; l++)
					acc += longint'(taps[k*3+l]) *
						longint'($signed(kernel_rows[k][COEF_BITS*l +: COEF_BITS]));
			// Q10.22 to Q16.16, round half up
			total = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
			total += longint'(psum);
			if (last_chan)
				total += longint'(bias_reg);
			if (total > SUM_MAX)
				total = SUM_MAX;
			if (total < SUM_MIN)
				total = SUM_MIN;
			if (last_chan && total < 0)
				total = 0;
			res.value = total[SUM_BITS-1:0];
			res.row = COORD_BITS'(r - 2);
			res.col = COORD_BITS'(c - 2);
			res.last = (r - 2 == n - 1) && (c - 2 == n - 1);
			due_results.push_back(res);
		end
		if (c + 1 >= w) begin
			scan_col = 0;
			scan_row = (r + 1 >= w) ? 0 : r + 1;
		end else begin
			scan_col = c + 1;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_en) begin
				case (cfg_index_t'(wr_index))
					CFG_KERNEL_TOP: kernel_rows[0] = wr_data;
					CFG_KERNEL_MID: kernel_rows[1] = wr_data;
					CFG_KERNEL_BOT: kernel_rows[2] = wr_data;
					CFG_BIAS:       bias_reg = wr_data[SUM_BITS-1:0];
					CFG_FRAME_SIZE: size_reg = wr_data[FS_BITS-1:0];
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				results_checked++;
				if (due_results.size() == 0) begin
					flag_error($sformatf("result %h at (%0d,%0d) with none outstanding",
						results.result, results.out_row, results.out_col));
				end else begin
					want = due_results.pop_front();
					if (results.result !== want.value)
						flag_error($sformatf("(%0d,%0d) result %h, expected %h",
							want.row, want.col, results.result, want.value));
					if (results.out_row !== want.row)
						flag_error($sformatf("out_row %0d, expected %0d",
							results.out_row, want.row));
					if (results.out_col !== want.col)
						flag_error($sformatf("out_col %0d, expected %0d",
							results.out_col, want.col));
					if (results.frame_end !== want.last)
						flag_error($sformatf("(%0d,%0d) frame_end %b, expected %b",
							want.row, want.col, results.frame_end, want.last));
				end
			end
			if (samples.valid && samples.ready)
				convolve_sample(samples.pixel, samples.partial_sum, samples.final_channel);
			pending = due_results.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// testbench: stimulus, handshake pacing and verdict for conv3x3_bias_relu_stream;
// results are checked by c3br_result_checker; depends on c3br_pkg and c3br_stream_ifs
module testbench;
	import c3br_pkg::*;

	localparam int GAP_MAX     = 18;    // longest idle draw on either side
	localparam int DRAIN_TAIL  = 10;    // five pipeline stages plus margin
	localparam int STALL_LIMIT = 2000;  // cycles without any transfer
	localparam int RANDOM_ITEMS = 60;   // random tail after the long-row stretch

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      wr_en;
	logic [CFG_INDEX_BITS-1:0] wr_index;
	logic [CFG_DATA_BITS-1:0]  wr_data;

	int          error_count;
	int          pending;
	int          results_checked;
	int          samples_sent = 0;
	int          reg_writes = 0;
	int          idle_cycles = 0;

	// mirror of the block's scan position, so planes can be completed
	int unsigned trk_row;
	int unsigned trk_col;
	int unsigned trk_width;

	// stretches with no idling on the sample side and the result side
	bit          src_calm = 1'b0;
	bit          sink_calm = 1'b0;

	c3br_in_if #(.PIXEL_BITS(PIXEL_BITS_DEF)) samples ();
	c3br_out_if results ();

	conv3x3_bias_relu_stream u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.results  (results),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	c3br_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.samples         (samples),
		.results         (results),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.error_count     (error_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: any stretch without a transfer on either channel is bounded
	always @(posedge clk) begin
		if (!arst_n || (samples.valid && samples.ready) || (results.valid && results.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				idle_cycles, pending);
			$display("testbench: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int unsigned draw_gap(input bit calm);
		return calm ? 0 : $urandom_range(0, GAP_MAX);
	endfunction

	// field generators lean on the extremes and on values near zero
	function automatic logic [15:0] pick_pixel();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 1023)) - 16'd512;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [31:0] pick_sum();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3, 4: return 32'($urandom_range(0, 8191)) - 32'd4096;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'h4000;   // +1.0
			4: return 16'hc000;   // -1.0
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_kernel_row();
		return {pick_coef(), pick_coef(), pick_coef()};
	endfunction

	// one sample transfer; valid stays high on return so back-to-back items need
	// no extra edge, the next call or settle() decides what happens to it
	task automatic send_item(input logic [15:0] px, input logic [31:0] psum, input bit fin);
		int unsigned gap;
		gap = draw_gap(src_calm);
		if ($urandom_range(0, 99) == 0)
			src_calm = !src_calm;
		if (gap != 0) begin
			samples.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples.valid <= 1'b1;
		samples.pixel <= px;
		samples.partial_sum <= psum;
		samples.final_channel <= fin;
		do @(posedge clk); while (!samples.ready);
		@(negedge clk);
		samples_sent++;
		if (trk_col + 1 >= trk_width) begin
			trk_col = 0;
			trk_row = (trk_row + 1 >= trk_width) ? 0 : trk_row + 1;
		end else begin
			trk_col++;
		end
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count)
			send_item(pick_pixel(), pick_sum(), 1'($urandom_range(0, 1)));
	endtask

	// runs on to the end of the current plane (a whole plane from the origin)
	task automatic send_plane_rest();
		do send_random(1); while (trk_row != 0 || trk_col != 0);
	endtask

	// stop sending, wait for every outstanding result, then let the pipeline empty
	task automatic settle();
		samples.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_TAIL) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
		reg_writes++;
		if (idx == CFG_FRAME_SIZE) begin
			trk_width = data[FS_BITS-1:0];
			if (trk_width < 1)
				trk_width = 1;
			if (trk_width > MAX_SIZE_DEF)
				trk_width = MAX_SIZE_DEF;
			trk_width += 2;
		end
	endtask

	// bits above a register's width carry noise; the block must drop them
	task automatic configure(input logic [CFG_DATA_BITS-1:0] k_top, k_mid, k_bot,
			input logic [SUM_BITS-1:0] bias, input logic [FS_BITS-1:0] size_code);
		write_reg(CFG_KERNEL_TOP, k_top);
		write_reg(CFG_KERNEL_MID, k_mid);
		write_reg(CFG_KERNEL_BOT, k_bot);
		write_reg(CFG_BIAS, {16'($urandom()), bias});
		write_reg(CFG_FRAME_SIZE, {$urandom(), 7'($urandom()), size_code});
	endtask

	// result side: ready drops for a drawn number of cycles after each transfer
	initial begin : result_sink
		int unsigned stall;
		bit          taken;
		stall = 0;
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			taken = results.valid && results.ready;
			@(negedge clk);
			if (taken) begin
				stall = draw_gap(sink_calm);
				if ($urandom_range(0, 47) == 0)
					sink_calm = !sink_calm;
			end
			if (stall == 0) begin
				results.ready <= 1'b1;
			end else begin
				results.ready <= 1'b0;
				stall--;
			end
		end
	end

	initial begin : stimulus
		int                 random_start;
		logic [FS_BITS-1:0] size_code;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = CFG_KERNEL_TOP;
		wr_data = '0;
		samples.valid = 1'b0;
		samples.pixel = '0;
		samples.partial_sum = '0;
		samples.final_channel = 1'b0;
		trk_row = 0;
		trk_col = 0;
		trk_width = FS_RESET + 2;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: zero kernel and bias, 224-wide plane; two padded rows
		// and a few samples reach the first output row, so results are psum (relu if final)
		send_random(2 * trk_width + 6);
		settle();
		// shrink the plane in mid-row: the column is past the new width and wraps,
		// the rest of the small plane reuses line entries already written
		write_reg(CFG_FRAME_SIZE, CFG_DATA_BITS'(2));
		send_plane_rest();

		// directed, single-pixel planes: positive saturation
		settle();
		configure({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, 32'h0, 9'd1);
		repeat (9) send_item(16'h7fff, 32'h7fff_ffff, 1'b0);
		// negative saturation kept on an intermediate channel
		repeat (9) send_item(16'h8000, 32'h8000_0000, 1'b0);
		settle();
		// size code zero behaves as one; bias on the final channel, relu clamps to zero
		configure({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 32'h7fff_ffff, 9'd0);
		repeat (9) send_item(16'h7fff, 32'h8000_0000, 1'b1);

		// largest code, clamped to 256: three full rows plus part of the next
		// cover every output column and fill both line buffers completely, so from
		// here on a size change in mid-plane can only read written entries
		settle();
		configure(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), pick_sum(),
			9'h1ff);
		send_random(3 * trk_width + $urandom_range(1, 20));

		// random settings; mostly small planes run to the end, larger ones are cut
		// off partway so the next setting lands in mid-plane
		random_start = samples_sent;
		while (samples_sent < random_start + RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(0, 19))
				0:       size_code = 9'd0;
				1:       size_code = 9'($urandom_range(257, 511));
				2, 3:    size_code = 9'($urandom_range(7, 20));
				default: size_code = 9'($urandom_range(1, 5));
			endcase
			configure(pick_kernel_row(), pick_kernel_row(), pick_kernel_row(), pick_sum(),
				size_code);
			if (trk_width <= 8) begin
				send_plane_rest();
				// hold the sender until the result channel has caught up
				if ($urandom_range(0, 3) == 0)
					settle();
				repeat ($urandom_range(0, 2)) send_plane_rest();
				if ($urandom_range(0, 2) == 0)
					send_random($urandom_range(1, 20));
			end else begin
				send_random($urandom_range(10, 120));
			end
		end

		settle();
		$display("run: %0d samples, %0d results compared, %0d register writes",
			samples_sent, results_checked, reg_writes);
		$display("run: sizes 0 to 511 with clamping, mid-plane resizing, saturation and relu");
		if (error_count == 0 && pending == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ===== conv3x3_bias_relu_stream.f =====
rtl/c3br_pkg.sv
rtl/c3br_stream_ifs.sv
rtl/c3br_window.sv
rtl/c3br_mac.sv
rtl/conv3x3_bias_relu_stream.sv
tb/sv/c3br_result_checker.sv
tb/sv/testbench.sv
